// ===== src/h264d_pkg.sv =====
`timescale 1ns / 1ps
// Package for the H.264 RTP depacketizer: result kind codes, NAL type codes
// and the result record types. No dependencies.
package h264d_pkg;

	// Kind of one result word.
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_CLOSE = 2'd2;
	localparam logic [1:0] KIND_ABORT = 2'd3;

	// NAL unit types handled specially.
	localparam logic [4:0] TYPE_STAP_A = 5'd24;
	localparam logic [4:0] TYPE_FU_A   = 5'd28;

	// FU header bit positions.
	localparam int FU_START_BIT = 7;
	localparam int FU_END_BIT   = 6;

	typedef struct packed {
		logic [7:0] data;
		logic [1:0] kind;
		logic       first;
	} res_t;

	// All results caused by one accepted payload word.
	typedef struct packed {
		res_t r1;
		res_t r0;
		logic two;
	} bundle_t;

endpackage

// ===== src/h264d_in_if.sv =====
`timescale 1ns / 1ps
// Payload channel of the H.264 RTP depacketizer: one RTP payload byte a word.
// Stands alone; no package needed.
interface h264d_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  payload_byte;
	logic        packet_first;
	logic        packet_last;
	logic [15:0] seq_number;

	modport source (output valid, output payload_byte, output packet_first,
		output packet_last, output seq_number, input ready);
	modport sink (input valid, input payload_byte, input packet_first,
		input packet_last, input seq_number, output ready);
endinterface

// ===== src/h264d_out_if.sv =====
`timescale 1ns / 1ps
// NAL channel of the H.264 RTP depacketizer: one NAL byte or marker a word.
// Stands alone; no package needed.
interface h264d_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] kind;
	logic       nal_first;
	logic       run_last;

	modport source (output valid, output out_byte, output kind,
		output nal_first, output run_last, input ready);
	modport sink (input valid, input out_byte, input kind,
		input nal_first, input run_last, output ready);
endinterface

// ===== src/h264_rtp_depacketizer.sv =====
`timescale 1ns / 1ps
// H.264 RTP depacketizer top level. An accepted word's results are registered in the
// result queue before being offered. Throughput: one payload word per cycle while
// each word yields at most one result and nal.ready is high; a word with two results
// is offered as two words, which sets the sustained rate. The two-entry result queue
// lets input be taken while results wait. Reset (arst_n low, asynchronous) clears all
// parsing state and empties the queue; the first packet afterwards is always taken.
module h264_rtp_depacketizer
	import h264d_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	h264d_in_if.sink    pkt,
	h264d_out_if.source nal
);

	// Packet parsing mode. Idle also covers a discarded packet.
	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_SINGLE,
		MODE_STAP,
		MODE_FU
	} mode_t;

	// Parsing state.
	logic [15:0] last_seq_q;
	logic        seq_seen_q;
	mode_t       mode_q;
	logic [1:0]  byte_pos_q;
	logic [1:0]  agg_phase_q;
	logic [15:0] agg_rem_q;
	logic        frag_open_q;
	logic [2:0]  ind_q;
	logic        frag_ends_q;

	logic [15:0] last_seq_d;
	logic        seq_seen_d;
	mode_t       mode_d;
	logic [1:0]  byte_pos_d;
	logic [1:0]  agg_phase_d;
	logic [15:0] agg_rem_d;
	logic        frag_open_d;
	logic [2:0]  ind_d;
	logic        frag_ends_d;

	// Results of the current word.
	res_t       res_d [2];
	logic [1:0] n_res;

	// Result queue: two bundles, each holding the results of one word.
	bundle_t    buf_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       sub_q;

	logic       accept;
	logic       push;
	logic       pop;
	logic       out_hs;
	bundle_t    head;
	res_t       head_res;
	logic [15:0] seq_diff;
	logic        late;
	logic        stap_open;
	logic        open_nal;
	logic [15:0] rem_dec;

	// A packet is late when its serial distance from the last accepted one
	// is negative, half-range included.
	assign seq_diff = pkt.seq_number - last_seq_q;
	assign late     = seq_seen_q && seq_diff[15];
	assign rem_dec  = agg_rem_q - 16'd1;

	assign stap_open = (mode_q == MODE_STAP) && (agg_phase_q == 2'd2);
	assign open_nal  = (mode_q == MODE_SINGLE) || stap_open
		|| ((mode_q == MODE_FU) && frag_open_q);

	// Output side: a bundle leaves the queue once its last result is taken.
	assign head     = buf_q[rptr_q];
	assign head_res = sub_q ? head.r1 : head.r0;
	assign nal.valid     = (cnt_q != 2'd0);
	assign nal.out_byte  = head_res.data;
	assign nal.kind      = head_res.kind;
	assign nal.nal_first = head_res.first;
	assign nal.run_last  = sub_q || !head.two;
	assign out_hs = nal.valid && nal.ready;
	assign pop    = out_hs && (sub_q || !head.two);

	// A word is taken whenever a bundle slot is free now or frees this cycle;
	// every word may need a slot.
	assign pkt.ready = (cnt_q != 2'd2) || pop;
	assign accept    = pkt.valid && pkt.ready;
	assign push      = accept && (n_res != 2'd0);

	// Single pass through the packet parser for one payload byte.
	always_comb begin
		last_seq_d  = last_seq_q;
		seq_seen_d  = seq_seen_q;
		mode_d      = mode_q;
		byte_pos_d  = byte_pos_q;
		agg_phase_d = agg_phase_q;
		agg_rem_d   = agg_rem_q;
		frag_open_d = frag_open_q;
		ind_d       = ind_q;
		frag_ends_d = frag_ends_q;
		res_d[0]    = '0;
		res_d[1]    = '0;
		n_res       = 2'd0;

		if (pkt.packet_first) begin
			// A new packet while the previous one never ended: drop what is open.
			if (mode_q != MODE_IDLE) begin
				if (open_nal) begin
					res_d[n_res[0]] = '{data: 8'd0, kind: KIND_ABORT, first: 1'b0};
					n_res = n_res + 2'd1;
				end
				if (mode_q == MODE_FU) begin
					frag_open_d = 1'b0;
				end
				mode_d = MODE_IDLE;
			end
			if (!late) begin
				last_seq_d = pkt.seq_number;
				seq_seen_d = 1'b1;
				if (pkt.payload_byte[4:0] == TYPE_FU_A) begin
					ind_d      = pkt.payload_byte[7:5];
					byte_pos_d = 2'd1;
					mode_d     = pkt.packet_last ? MODE_IDLE : MODE_FU;
				end else begin
					// Any other packet type ends a pending fragmented NAL.
					if (frag_open_d) begin
						res_d[n_res[0]] = '{data: 8'd0, kind: KIND_ABORT, first: 1'b0};
						n_res = n_res + 2'd1;
						frag_open_d = 1'b0;
					end
					if (pkt.payload_byte[4:0] == TYPE_STAP_A) begin
						agg_phase_d = 2'd0;
						agg_rem_d   = 16'd0;
						mode_d      = pkt.packet_last ? MODE_IDLE : MODE_STAP;
					end else begin
						res_d[n_res[0]] = '{data: pkt.payload_byte,
							kind: pkt.packet_last ? KIND_END : KIND_DATA, first: 1'b1};
						n_res = n_res + 2'd1;
						mode_d = pkt.packet_last ? MODE_IDLE : MODE_SINGLE;
					end
				end
			end
		end else begin
			case (mode_q)
				MODE_SINGLE: begin
					res_d[0] = '{data: pkt.payload_byte,
						kind: pkt.packet_last ? KIND_END : KIND_DATA, first: 1'b0};
					n_res = 2'd1;
				end
				MODE_STAP: begin
					case (agg_phase_q)
						2'd0: begin
							agg_rem_d   = {pkt.payload_byte, 8'd0};
							agg_phase_d = 2'd1;
						end
						2'd1: begin
							agg_rem_d   = {agg_rem_q[15:8], pkt.payload_byte};
							// A zero-length unit is skipped.
							agg_phase_d = ({agg_rem_q[15:8], pkt.payload_byte} != 16'd0)
								? 2'd2 : 2'd0;
							byte_pos_d  = 2'd0;
						end
						default: begin
							byte_pos_d = 2'd1;
							agg_rem_d  = rem_dec;
							if (rem_dec == 16'd0) begin
								res_d[0] = '{data: pkt.payload_byte, kind: KIND_END,
									first: (byte_pos_q == 2'd0)};
								n_res       = 2'd1;
								agg_phase_d = 2'd0;
							end else begin
								res_d[0] = '{data: pkt.payload_byte, kind: KIND_DATA,
									first: (byte_pos_q == 2'd0)};
								n_res = 2'd1;
								// Packet ends inside a unit: the unit is truncated.
								if (pkt.packet_last) begin
									res_d[1] = '{data: 8'd0, kind: KIND_ABORT, first: 1'b0};
									n_res    = 2'd2;
								end
							end
						end
					endcase
				end
				MODE_FU: begin
					if (byte_pos_q == 2'd1) begin
						// FU header byte.
						frag_ends_d = pkt.payload_byte[FU_END_BIT];
						byte_pos_d  = 2'd2;
						if (pkt.payload_byte[FU_START_BIT]) begin
							if (frag_open_q) begin
								res_d[n_res[0]] = '{data: 8'd0, kind: KIND_ABORT,
									first: 1'b0};
								n_res = n_res + 2'd1;
							end
							frag_open_d = 1'b1;
							// Rebuilt NAL header: F and NRI from the indicator,
							// type from the FU header.
							if (pkt.packet_last && pkt.payload_byte[FU_END_BIT]) begin
								res_d[n_res[0]] = '{data: {ind_q, pkt.payload_byte[4:0]},
									kind: KIND_END, first: 1'b1};
								frag_open_d = 1'b0;
							end else begin
								res_d[n_res[0]] = '{data: {ind_q, pkt.payload_byte[4:0]},
									kind: KIND_DATA, first: 1'b1};
							end
							n_res = n_res + 2'd1;
						end else if (!frag_open_q) begin
							// Orphan fragment: discard the rest of the packet.
							mode_d = MODE_IDLE;
						end else if (pkt.packet_last && pkt.payload_byte[FU_END_BIT]) begin
							res_d[0]    = '{data: 8'd0, kind: KIND_CLOSE, first: 1'b0};
							n_res       = 2'd1;
							frag_open_d = 1'b0;
						end
					end else begin
						if (pkt.packet_last && frag_ends_q) begin
							res_d[0]    = '{data: pkt.payload_byte, kind: KIND_END,
								first: 1'b0};
							frag_open_d = 1'b0;
						end else begin
							res_d[0] = '{data: pkt.payload_byte, kind: KIND_DATA,
								first: 1'b0};
						end
						n_res = 2'd1;
					end
				end
				default: begin
				end
			endcase
			if (pkt.packet_last) begin
				mode_d = MODE_IDLE;
			end
		end
	end

	// Parsing state and queue control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_seq_q  <= '0;
			seq_seen_q  <= 1'b0;
			mode_q      <= MODE_IDLE;
			byte_pos_q  <= '0;
			agg_phase_q <= '0;
			agg_rem_q   <= '0;
			frag_open_q <= 1'b0;
			ind_q       <= '0;
			frag_ends_q <= 1'b0;
			wptr_q      <= 1'b0;
			rptr_q      <= 1'b0;
			cnt_q       <= '0;
			sub_q       <= 1'b0;
		end else begin
			if (accept) begin
				last_seq_q  <= last_seq_d;
				seq_seen_q  <= seq_seen_d;
				mode_q      <= mode_d;
				byte_pos_q  <= byte_pos_d;
				agg_phase_q <= agg_phase_d;
				agg_rem_q   <= agg_rem_d;
				frag_open_q <= frag_open_d;
				ind_q       <= ind_d;
				frag_ends_q <= frag_ends_d;
			end
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
			if (out_hs) begin
				sub_q <= !pop;
			end
		end
	end

	// Queue payload needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wptr_q] <= '{r1: res_d[1], r0: res_d[0], two: (n_res == 2'd2)};
		end
	end

endmodule
